>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; the user supplies clock and reset by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked check, live through reset too.
`define ASSERT_CLK_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`endif

>>> design/lrag_pkg.sv
// Shared types and constants for the LED ring animation generator.
// Used by the pixel walker and the top level; depends on nothing.
package lrag_pkg;

   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 24;
   localparam int SPEED_W       = 20;
   localparam int COUNT_W       = 22;
   localparam int PIXEL_INDEX_W = 6;
   localparam int QUOT_W        = 9;

   typedef logic [23:0] rgb_type;
   typedef logic [2:0]  mode_type;

   localparam mode_type MODE_CLEAR     = 3'd0;
   localparam mode_type MODE_CHASE     = 3'd1;
   localparam mode_type MODE_EYE       = 3'd2;
   localparam mode_type MODE_RAINBOW   = 3'd3;
   localparam mode_type MODE_COUNTDOWN = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHASE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BODY      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_TAIL = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAR_TAIL  = 3'd6;

   localparam logic [11:0] HOUR_S     = 12'd3600;
   localparam logic [9:0]  CLEAR_MS   = 10'd1000;
   localparam logic [2:0]  CHASE_LAST = 3'd4;

   // floor(x / 3600) = (x * HOUR_RECIP) >> HOUR_SHIFT for x below 2^21
   localparam int                      HOUR_RECIP_W = 21;
   localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP   = 21'd1193047;
   localparam int                      HOUR_SHIFT   = 32;

   typedef struct packed {
      mode_type mode;
      rgb_type  chase_color;
      rgb_type  head_color;
      rgb_type  body_color;
      rgb_type  near_tail_color;
      rgb_type  far_tail_color;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic step;
   } walk_ctl_type;

endpackage

>>> design/lrag_pixel_gen.sv
// Pixel walker: steps through the ring one pixel per step and gives its colour.
// Keeps ring offsets and the wheel position as running counters; uses lrag_pkg.
module lrag_pixel_gen #(
   parameter int RING_PIXELS = 24
) (
   input  logic                             clock,
   input  lrag_pkg::walk_ctl_type           ctl,
   input  lrag_pkg::cfg_type                cfg,
   input  lrag_pkg::rgb_type                eye_head,
   input  logic [2:0]                       chase_phase,
   input  logic [$clog2(RING_PIXELS)-1:0]   eye_position,
   input  logic [7:0]                       wheel_offset,
   output logic [$clog2(RING_PIXELS)-1:0]   pixel_index,
   output lrag_pkg::rgb_type                color,
   output logic                             last_pixel
);
   import lrag_pkg::*;

   localparam int PW = $clog2(RING_PIXELS);
   localparam logic [PW-1:0] LAST_P    = PW'(RING_PIXELS - 1);
   localparam logic [PW-1:0] RING_LOW  = PW'(RING_PIXELS);
   localparam logic [PW:0]   RING_N    = (PW+1)'(RING_PIXELS);
   localparam logic [7:0]    WHEEL_Q   = 8'(256 / RING_PIXELS);
   localparam logic [PW:0]   WHEEL_R   = (PW+1)'(256 % RING_PIXELS);
   localparam logic [3:0]    RING_MOD5 = 4'(RING_PIXELS % 5);
   localparam logic [3:0]    CHASE_STEP = 4'd5;
   localparam logic [PW-1:0] EYE_FAR   = PW'(0);
   localparam logic [PW-1:0] EYE_NEAR  = PW'(1);
   localparam logic [PW-1:0] EYE_BODY_END = PW'(4);
   localparam logic [PW-1:0] EYE_HEAD  = PW'(5);
   localparam logic [7:0]    THIRD     = 8'd85;
   localparam logic [7:0]    TWO_THIRD = 8'd170;

   logic [PW-1:0] p_ff, p_in;
   logic [PW-1:0] rel_ff, rel_in;
   logic [PW-1:0] off_ff, off_in;
   logic [2:0]    m5_ff, m5_in;
   logic [7:0]    q_ff, q_in;
   logic [PW-1:0] r_ff, r_in;

   logic [PW:0]   r_sum;
   logic          r_wrap;
   logic [3:0]    m5_sum;
   logic [7:0]    wheel_pos;
   logic [7:0]    w;
   logic [7:0]    wa;
   logic [7:0]    w3;
   rgb_type       wheel_color;
   rgb_type       eye_color;

   assign r_sum  = {1'b0, r_ff} + WHEEL_R;
   assign r_wrap = (r_sum >= RING_N);
   assign m5_sum = RING_MOD5 + CHASE_STEP - {1'b0, chase_phase};

   always_comb begin
      p_in   = p_ff;
      rel_in = rel_ff;
      off_in = off_ff;
      m5_in  = m5_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      if (ctl.load) begin
         p_in   = '0;
         q_in   = '0;
         r_in   = '0;
         rel_in = (chase_phase == 3'd0) ? '0 : RING_LOW - PW'(chase_phase);
         off_in = (eye_position == '0) ? '0 : RING_LOW - eye_position;
         if (chase_phase == 3'd0) begin
            m5_in = '0;
         end else if (m5_sum >= CHASE_STEP) begin
            m5_in = 3'(m5_sum - CHASE_STEP);
         end else begin
            m5_in = 3'(m5_sum);
         end
      end else if (ctl.step) begin
         p_in   = p_ff + PW'(1);
         rel_in = (rel_ff == LAST_P) ? '0 : rel_ff + PW'(1);
         off_in = (off_ff == LAST_P) ? '0 : off_ff + PW'(1);
         if (rel_ff == LAST_P || m5_ff == CHASE_LAST) begin
            m5_in = '0;
         end else begin
            m5_in = m5_ff + 3'd1;
         end
         q_in = q_ff + WHEEL_Q + {7'd0, r_wrap};
         r_in = r_wrap ? PW'(r_sum - RING_N) : PW'(r_sum);
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      rel_ff <= rel_in;
      off_ff <= off_in;
      m5_ff  <= m5_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
   end

   assign wheel_pos = q_ff + wheel_offset;
   assign w         = ~wheel_pos;

   always_comb begin
      priority if (w < THIRD) begin
         wa = w;
      end else if (w < TWO_THIRD) begin
         wa = w - THIRD;
      end else begin
         wa = w - TWO_THIRD;
      end
      w3 = (wa << 1) + wa;
      priority if (w < THIRD) begin
         wheel_color = {~w3, 8'h00, w3};
      end else if (w < TWO_THIRD) begin
         wheel_color = {8'h00, w3, ~w3};
      end else begin
         wheel_color = {w3, ~w3, 8'h00};
      end
   end

   always_comb begin
      priority if (off_ff == EYE_FAR) begin
         eye_color = cfg.far_tail_color;
      end else if (off_ff == EYE_NEAR) begin
         eye_color = cfg.near_tail_color;
      end else if (off_ff <= EYE_BODY_END) begin
         eye_color = cfg.body_color;
      end else if (off_ff == EYE_HEAD) begin
         eye_color = eye_head;
      end else begin
         eye_color = '0;
      end
   end

   always_comb begin
      unique case (cfg.mode)
         MODE_CHASE:                color = (m5_ff == 3'd0) ? cfg.chase_color : '0;
         MODE_EYE, MODE_COUNTDOWN:  color = eye_color;
         MODE_RAINBOW:              color = wheel_color;
         default:                   color = '0;
      endcase
   end

   assign pixel_index = p_ff;
   assign last_pixel  = (p_ff == LAST_P);

endmodule

>>> design/led_ring_animation_generator.sv
// Top level of the LED ring animation generator: registers, frame timer, sequencer.
// Instantiates lrag_pixel_gen; uses lrag_pkg.
//
// Use:
//   req_*  : one item per millisecond tick; req_tdata[0] is restart (1 clears the
//            animation positions and emits a frame at once).
//   rsp_*  : one item per pixel, pixel 0 first; rsp_tlast marks the last pixel.
//   csr_*  : register writes (index, data), always ready; write only while idle.
// Sequence:
//   A tick that emits no frame only counts the frame timer down and stays idle.
//   A tick that emits a frame passes through the accepting state, a state for the
//   reciprocal multiply that forms the whole hours for countdown mode, one for the
//   frame delay product, then one pixel per cycle out of the walker while rsp does not stall.
//   The next item is taken once the last pixel sits in the output register.
// Reset: registers return to their defaults, timer and positions to zero, so the
//   first tick emits a frame.
// Stall: a stalled rsp side holds the current pixel and freezes the walker.
module led_ring_animation_generator #(
   parameter int RING_PIXELS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrag_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lrag_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [5:0] pixel_index, [13:6] red,
                                                           // [21:14] green, [29:22] blue
   output logic                                rsp_tlast,  // last_pixel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrag_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrag_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lrag_pkg::*;

   localparam int PW = $clog2(RING_PIXELS);
   localparam logic [PW-1:0] LAST_P = PW'(RING_PIXELS - 1);
   localparam int REM_W = SPEED_W + 1;
   localparam int HOUR_PROD_W = REM_W + HOUR_RECIP_W;

   localparam cfg_type CFG_RESET = '{
      mode:            MODE_CLEAR,
      chase_color:     24'hFFFFFF,
      head_color:      24'hCD5C5C,
      body_color:      24'h008000,
      near_tail_color: 24'h004E00,
      far_tail_color:  24'h001C00
   };
   localparam logic [SPEED_W-1:0] SPEED_RESET = 20'd20;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_DELAY, S_EMIT} state_type;

   state_type              state_ff, state_in;
   cfg_type                cfg_ff, cfg_in;
   logic [SPEED_W-1:0]     speed_ff, speed_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [2:0]             phase_ff, phase_in;
   logic [PW-1:0]          eye_ff, eye_in;
   logic [7:0]             wheel_ff, wheel_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [QUOT_W-1:0]      quot_ff, quot_in;
   logic [COUNT_W-1:0]     delay_ff, delay_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   walk_ctl_type           walk_ctl;
   rgb_type                eye_head;
   rgb_type                pix_color;
   logic [PW-1:0]          pix_index;
   logic                   pix_last;
   logic [HOUR_PROD_W-1:0] hour_prod;
   logic [18:0]            hour_ms;
   logic                   out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign hour_prod = HOUR_PROD_W'(rem_ff) * HOUR_PROD_W'(HOUR_RECIP);
   assign hour_ms   = 19'(quot_ff) * 19'(CLEAR_MS);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign eye_head  = (cfg_ff.mode == MODE_COUNTDOWN && quot_ff > QUOT_W'(1))
                      ? cfg_ff.body_color : cfg_ff.head_color;

   lrag_pixel_gen #(
      .RING_PIXELS (RING_PIXELS)
   ) u_pixel_gen (
      .clock        (clock),
      .ctl          (walk_ctl),
      .cfg          (cfg_ff),
      .eye_head     (eye_head),
      .chase_phase  (phase_ff),
      .eye_position (eye_ff),
      .wheel_offset (wheel_ff),
      .pixel_index  (pix_index),
      .color        (pix_color),
      .last_pixel   (pix_last)
   );

   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      speed_in     = speed_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      eye_in       = eye_ff;
      wheel_in     = wheel_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      delay_in     = delay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      walk_ctl     = '{load: 1'b0, step: 1'b0};

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:      cfg_in.mode            = csr_data[2:0];
            CSR_SPEED:     speed_in               = csr_data[SPEED_W-1:0];
            CSR_CHASE:     cfg_in.chase_color     = csr_data;
            CSR_HEAD:      cfg_in.head_color      = csr_data;
            CSR_BODY:      cfg_in.body_color      = csr_data;
            CSR_NEAR_TAIL: cfg_in.near_tail_color = csr_data;
            CSR_FAR_TAIL:  cfg_in.far_tail_color  = csr_data;
            default:       cfg_in                 = cfg_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[0] || count_ff <= COUNT_W'(1)) begin
                  if (req_tdata[0]) begin
                     phase_in = '0;
                     eye_in   = '0;
                     wheel_in = '0;
                  end
                  rem_in   = {1'b0, speed_ff} + REM_W'(HOUR_S - 12'd1);
                  state_in = S_DIV;
               end else begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         S_DIV: begin
            quot_in  = hour_prod[HOUR_SHIFT +: QUOT_W];
            state_in = S_DELAY;
         end
         S_DELAY: begin
            unique case (cfg_ff.mode)
               MODE_CHASE:   delay_in = COUNT_W'({speed_ff, 1'b0});
               MODE_EYE:     delay_in = COUNT_W'(speed_ff);
               MODE_RAINBOW: delay_in = COUNT_W'(speed_ff >> 1);
               MODE_COUNTDOWN: begin
                  delay_in = (quot_ff <= QUOT_W'(1)) ? COUNT_W'(speed_ff)
                                                     : COUNT_W'(hour_ms);
               end
               default:      delay_in = COUNT_W'(CLEAR_MS);
            endcase
            walk_ctl.load = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {2'b00, pix_color[7:0], pix_color[15:8], pix_color[23:16],
                                PIXEL_INDEX_W'(pix_index)};
               rsp_last_in   = pix_last;
               walk_ctl.step = 1'b1;
               if (pix_last) begin
                  count_in = delay_ff;
                  state_in = S_IDLE;
                  unique case (cfg_ff.mode)
                     MODE_CHASE:   phase_in = (phase_ff == CHASE_LAST) ? '0 : phase_ff + 3'd1;
                     MODE_EYE, MODE_COUNTDOWN: eye_in = (eye_ff == LAST_P) ? '0 : eye_ff + PW'(1);
                     MODE_RAINBOW: wheel_in = wheel_ff + 8'd1;
                     default:      phase_in = phase_ff;
                  endcase
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_ff       <= CFG_RESET;
         speed_ff     <= SPEED_RESET;
         count_ff     <= '0;
         phase_ff     <= '0;
         eye_ff       <= '0;
         wheel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         speed_ff     <= speed_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         eye_ff       <= eye_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      delay_ff    <= delay_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> design/lrag_checker.sv
// Port-level checks for the LED ring animation generator, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module lrag_checker #(
   parameter int RING_PIXELS = 24
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   `ASSERT_CLK(rsp_valid_holds, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp item dropped")
   `ASSERT_CLK(rsp_data_holds, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp item changed")
   `ASSERT_CLK_ALL(rsp_idle_after_reset, reset |=> !rsp_tvalid, "rsp valid after reset")
   `ASSERT_CLK(last_index, rsp_tvalid && rsp_tlast |-> rsp_tdata[5:0] == 6'(RING_PIXELS - 1), "tlast off the last pixel")
   `ASSERT_CLK(index_in_order, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tdata[5:0] == $past(rsp_tdata[5:0]) + 6'd1, "pixel skipped or late")

endmodule

bind led_ring_animation_generator lrag_checker #(.RING_PIXELS(RING_PIXELS)) u_lrag_checker (.*);
